// ----- rtl/pem_pkg.sv -----
// ----------------------------------------------------------------------------
// pem_pkg
// Shared types and constants of the Prewitt edge magnitude block.
// ----------------------------------------------------------------------------
package pem_pkg;

   localparam int PIX_W  = 8;
   localparam int GRAD_W = 11;
   localparam int FW_W   = 12;
   localparam int FH_W   = 16;
   localparam int CSR_W  = 16;
   localparam int SUM_W  = 22;
   localparam int ROOT_W = 16;
   localparam int ISQ_STEPS = 8;

   // item codes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // register indexes
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // one classified result on its way to the magnitude unit
   typedef struct packed {
      logic                     corner;
      logic [PIX_W-1:0]         cval;
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
      logic                     last;
   } pem_entry_type;

endpackage

// ----- rtl/pem_queue.sv -----
// ----------------------------------------------------------------------------
// pem_queue
// Four-entry queue between the window front end and the magnitude unit.
// ----------------------------------------------------------------------------
module pem_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pem_pkg::pem_entry_type push_data,
   output logic                  full,
   input  logic                  pop,
   output pem_pkg::pem_entry_type pop_data,
   output logic                  empty
);
   import pem_pkg::*;

   localparam int DEPTH = 4;
   localparam int IW    = $clog2(DEPTH);

   pem_entry_type      mem_ff [DEPTH];
   logic [IW-1:0]      wr_ff, wr_in;
   logic [IW-1:0]      rd_ff, rd_in;
   logic [IW:0]        cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full     = (cnt_ff == (IW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (IW+1)'(do_push) - (IW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/pem_front.sv -----
// ----------------------------------------------------------------------------
// pem_front
// Accepts pixels and drain ticks, keeps line stores and the 3x3 window, and
// classifies each result into border flags and Prewitt gradients.
// ----------------------------------------------------------------------------
module pem_front #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [pem_pkg::CSR_W-1:0] csr_wdata,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_opcode,
   input  logic [pem_pkg::PIX_W-1:0] req_pixel_in,
   output logic                      q_push,
   output pem_pkg::pem_entry_type    q_data,
   input  logic                      q_full
);
   import pem_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH + 1);
   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int PW   = $clog2(MAX_WIDTH + 2);
   localparam int CMPW = (CW > FW_W) ? CW : FW_W;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   typedef logic [8:0][PIX_W-1:0] win_type;

   state_type          state_ff, state_in;
   logic               op_ff;
   logic [PIX_W-1:0]   px_ff;
   logic [CW-1:0]      col_ff, col_in;
   logic [FH_W-1:0]    row_ff, row_in;
   logic [PW-1:0]      pend_ff, pend_in;
   win_type            win_ff, win_in;
   logic [FW_W-1:0]    width_ff;
   logic [FH_W-1:0]    height_ff;
   logic [2*PIX_W-1:0] rd_ff;
   logic [2*PIX_W-1:0] mem [MAX_WIDTH];

   logic [CMPW-1:0]    fw_ext, w_clamp;
   logic [CW-1:0]      eff_w;
   logic [FH_W-1:0]    eff_h;
   logic               restart_c, emit_c, use_end_c, mem_we, commit;
   logic [CW-1:0]      c_c, ocol_c, c_inc;
   logic [FH_W-1:0]    r_c, orow_c, r_inc;
   win_type            winb_c, ws_c, nbe_c, nb_c;
   logic [PIX_W-1:0]   px_eff, up1, up2;
   logic               top, bot, lft, rgt;
   logic [8:0][PIX_W-1:0]      m_c;
   logic signed [GRAD_W-1:0]   gx_c, gy_c;

   // effective frame size
   always_comb begin
      fw_ext = CMPW'(width_ff);
      if (fw_ext < CMPW'(3)) begin
         w_clamp = CMPW'(3);
      end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
         w_clamp = CMPW'(MAX_WIDTH);
      end else begin
         w_clamp = fw_ext;
      end
      eff_w = CW'(w_clamp);
      eff_h = (height_ff < FH_W'(3)) ? FH_W'(3) : height_ff;
   end

   assign req_full = (state_ff != S_IDLE);
   assign up2      = rd_ff[2*PIX_W-1:PIX_W];
   assign up1      = rd_ff[PIX_W-1:0];
   assign px_eff   = (op_ff == OP_DRAIN) ? '0 : px_ff;

   // position and window of the current item, new frame on a pixel after a frame end
   always_comb begin
      restart_c = (op_ff == OP_PIXEL) && (pend_ff != '0);
      c_c       = restart_c ? '0 : col_ff;
      r_c       = restart_c ? '0 : row_ff;
      winb_c    = restart_c ? '0 : win_ff;
      c_inc     = c_c + 1'b1;
      r_inc     = r_c + 1'b1;
      for (int i = 0; i < 3; i++) begin
         ws_c[i*3+0]  = winb_c[i*3+1];
         ws_c[i*3+1]  = winb_c[i*3+2];
         nbe_c[i*3+0] = winb_c[i*3+1];
         nbe_c[i*3+1] = winb_c[i*3+2];
         nbe_c[i*3+2] = '0;
      end
      ws_c[2] = up2;
      ws_c[5] = up1;
      ws_c[8] = px_eff;
   end

   // item sequencing
   always_comb begin
      emit_c    = 1'b0;
      use_end_c = 1'b0;
      mem_we    = 1'b0;
      orow_c    = '0;
      ocol_c    = c_c - 1'b1;
      col_in    = col_ff;
      row_in    = row_ff;
      pend_in   = pend_ff;
      win_in    = win_ff;
      if (op_ff == OP_PIXEL) begin
         mem_we = 1'b1;
         win_in = ws_c;
         if (c_c == '0 && r_c >= FH_W'(2)) begin
            emit_c    = 1'b1;
            use_end_c = 1'b1;
            orow_c    = r_c - FH_W'(2);
         end else if (c_c != '0 && r_c != '0) begin
            emit_c = 1'b1;
            orow_c = r_c - 1'b1;
         end
         pend_in = '0;
         if (c_inc >= eff_w) begin
            col_in = '0;
            if (r_inc >= eff_h) begin
               row_in  = '0;
               pend_in = PW'(eff_w) + 1'b1;
            end else begin
               row_in = r_inc;
            end
         end else begin
            col_in = c_inc;
            row_in = r_c;
         end
      end else if (pend_ff == PW'(1)) begin
         emit_c    = 1'b1;
         use_end_c = 1'b1;
         orow_c    = eff_h - 1'b1;
         col_in    = '0;
         row_in    = '0;
         pend_in   = '0;
         win_in    = '0;
      end else if (pend_ff != '0) begin
         mem_we  = 1'b1;
         win_in  = ws_c;
         emit_c  = 1'b1;
         pend_in = pend_ff - 1'b1;
         col_in  = (c_inc >= eff_w) ? '0 : c_inc;
         if (c_c == '0) begin
            use_end_c = 1'b1;
            orow_c    = eff_h - FH_W'(2);
         end else begin
            orow_c = eff_h - 1'b1;
         end
      end
      if (use_end_c) begin
         ocol_c = eff_w - 1'b1;
      end
   end

   // border classification and gradients
   always_comb begin
      nb_c = use_end_c ? nbe_c : ws_c;
      top  = (orow_c == '0);
      bot  = (orow_c == eff_h - 1'b1);
      lft  = (ocol_c == '0);
      rgt  = (ocol_c == eff_w - 1'b1);
      for (int i = 0; i < 9; i++) begin
         if (((i / 3 == 0) && top) || ((i / 3 == 2) && bot) ||
             ((i % 3 == 0) && lft) || ((i % 3 == 2) && rgt)) begin
            m_c[i] = '0;
         end else begin
            m_c[i] = nb_c[i];
         end
      end
      gx_c = GRAD_W'(m_c[2]) + GRAD_W'(m_c[5]) + GRAD_W'(m_c[8])
           - GRAD_W'(m_c[0]) - GRAD_W'(m_c[3]) - GRAD_W'(m_c[6]);
      gy_c = GRAD_W'(m_c[6]) + GRAD_W'(m_c[7]) + GRAD_W'(m_c[8])
           - GRAD_W'(m_c[0]) - GRAD_W'(m_c[1]) - GRAD_W'(m_c[2]);
      q_data.corner = (top || bot) && (lft || rgt);
      q_data.cval   = nb_c[4];
      q_data.gx     = gx_c;
      q_data.gy     = gy_c;
      q_data.last   = bot && rgt;
   end

   assign commit   = (state_ff == S_EXEC) && (!emit_c || !q_full);
   assign q_push   = (state_ff == S_EXEC) && emit_c && !q_full;
   assign state_in = (state_ff == S_IDLE) ? ((req_push) ? S_EXEC : S_IDLE)
                                          : (commit ? S_IDLE : S_EXEC);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         col_ff    <= '0;
         row_ff    <= '0;
         pend_ff   <= '0;
         win_ff    <= '0;
         width_ff  <= FW_W'(640);
         height_ff <= FH_W'(480);
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            if (csr_index == CSR_FRAME_WIDTH) begin
               width_ff <= csr_wdata[FW_W-1:0];
            end else begin
               height_ff <= csr_wdata[FH_W-1:0];
            end
            col_ff  <= '0;
            row_ff  <= '0;
            pend_ff <= '0;
            win_ff  <= '0;
         end else if (commit) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            pend_ff <= pend_in;
            win_ff  <= win_in;
         end
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_push) begin
         op_ff <= req_opcode;
         px_ff <= req_pixel_in;
      end
   end

   // line stores: upper byte two rows up, lower byte one row up
   always_ff @(posedge clock) begin
      rd_ff <= mem[col_ff[AW-1:0]];
      if (commit && mem_we) begin
         mem[c_c[AW-1:0]] <= {up1, px_eff};
      end
   end

endmodule

// ----- rtl/pem_back.sv -----
// ----------------------------------------------------------------------------
// pem_back
// Magnitude unit: squares the gradients, takes a pipelined integer square
// root one bit pair per stage, clamps, passes the centre pixel at corners and holds the result for transfer.
// ----------------------------------------------------------------------------
module pem_back (
   input  logic                      clock,
   input  logic                      reset,
   input  pem_pkg::pem_entry_type    q_data,
   input  logic                      q_empty,
   output logic                      q_pop,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [pem_pkg::PIX_W-1:0] rsp_pixel_out,
   output logic                      rsp_frame_last
);
   import pem_pkg::*;

   localparam int NS = ISQ_STEPS + 1;

   logic [NS-1:0]     vld_ff;
   logic [ROOT_W-1:0] v_ff    [NS];
   logic [ROOT_W-1:0] root_ff [NS];
   logic              sat_ff  [NS];
   logic              corner_ff [NS];
   logic [PIX_W-1:0]  cval_ff [NS];
   logic              last_ff [NS];
   logic              out_vld_ff;
   logic [PIX_W-1:0]  out_pix_ff;
   logic              out_last_ff;
   logic              adv;
   logic signed [SUM_W-1:0] sq_x, sq_y;
   logic [SUM_W-1:0]  sum_c;

   assign adv       = !vld_ff[NS-1] || !out_vld_ff || rsp_pop;
   assign q_pop     = adv && !q_empty;
   assign rsp_empty = !out_vld_ff;
   assign rsp_pixel_out  = out_pix_ff;
   assign rsp_frame_last = out_last_ff;

   // squared sum
   always_comb begin
      sq_x  = SUM_W'(q_data.gx) * SUM_W'(q_data.gx);
      sq_y  = SUM_W'(q_data.gy) * SUM_W'(q_data.gy);
      sum_c = SUM_W'(sq_x) + SUM_W'(sq_y);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], !q_empty};
      end
   end

   // first stage
   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff[0]      <= sum_c[ROOT_W-1:0];
         root_ff[0]   <= '0;
         sat_ff[0]    <= (sum_c[SUM_W-1:ROOT_W] != '0);
         corner_ff[0] <= q_data.corner;
         cval_ff[0]   <= q_data.cval;
         last_ff[0]   <= q_data.last;
      end
   end

   // square root steps
   for (genvar k = 1; k < NS; k++) begin : g_isq
      localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (ROOT_W - 2 - 2 * (k - 1));
      logic [ROOT_W:0] trial;
      assign trial = {1'b0, root_ff[k-1]} + {1'b0, BIT};
      always_ff @(posedge clock) begin
         if (adv) begin
            if ({1'b0, v_ff[k-1]} >= trial) begin
               v_ff[k]    <= v_ff[k-1] - trial[ROOT_W-1:0];
               root_ff[k] <= (root_ff[k-1] >> 1) + BIT;
            end else begin
               v_ff[k]    <= v_ff[k-1];
               root_ff[k] <= root_ff[k-1] >> 1;
            end
            sat_ff[k]    <= sat_ff[k-1];
            corner_ff[k] <= corner_ff[k-1];
            cval_ff[k]   <= cval_ff[k-1];
            last_ff[k]   <= last_ff[k-1];
         end
      end
   end

   // output register, a waiting result is kept until its transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[NS-1] || (out_vld_ff && !rsp_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (adv && vld_ff[NS-1]) begin
         out_last_ff <= last_ff[NS-1];
         if (corner_ff[NS-1]) begin
            out_pix_ff <= cval_ff[NS-1];
         end else if (sat_ff[NS-1] || root_ff[NS-1][ROOT_W-1:PIX_W] != '0) begin
            out_pix_ff <= '1;
         end else begin
            out_pix_ff <= root_ff[NS-1][PIX_W-1:0];
         end
      end
   end

endmodule

// ----- rtl/prewitt_edge_magnitude.sv -----
// ----------------------------------------------------------------------------
// prewitt_edge_magnitude
// Streaming 3x3 Prewitt edge magnitude over raster-order grey pixels.
// ----------------------------------------------------------------------------
// The front end takes no new item until it is through with the last one: the
// line store is read with a registered port in the cycle of the transfer, and
// the window and line store are updated when the item commits, which waits
// while the queue is full. Results enter a four-entry queue and then a
// ten-stage magnitude unit (squares, eight square-root steps, output
// register), and leave at up to one per cycle while each is popped. Results
// lag the pixels by one row plus one pixel; after a frame, frame_width + 1
// drain ticks flush the tail. The line stores need no clearing after reset.
module prewitt_edge_magnitude #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [pem_pkg::CSR_W-1:0] csr_wdata,
   input  logic                      push,
   output logic                      full,
   input  logic                      req_opcode,
   input  logic [pem_pkg::PIX_W-1:0] req_pixel_in,
   output logic                      empty,
   input  logic                      pop,
   output logic [pem_pkg::PIX_W-1:0] rsp_pixel_out,
   output logic                      rsp_frame_last
);
   import pem_pkg::*;

   pem_entry_type f_data, b_data;
   logic          q_push, q_full, q_pop, q_empty;

   pem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_push     (push),
      .req_full     (full),
      .req_opcode   (req_opcode),
      .req_pixel_in (req_pixel_in),
      .q_push       (q_push),
      .q_data       (f_data),
      .q_full       (q_full)
   );

   pem_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (f_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (b_data),
      .empty     (q_empty)
   );

   pem_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_data         (b_data),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_empty      (empty),
      .rsp_pop        (pop),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last)
   );

   // queue is never written while full
   assert property (@(posedge clock) disable iff (reset) !(q_push && q_full))
      else $error("queue overrun");

   // queue is never read while empty
   assert property (@(posedge clock) disable iff (reset) !(q_pop && q_empty && !q_push))
      else $error("queue underrun");

   // no result straight after reset
   assert property (@(posedge clock) reset |=> empty)
      else $error("result present after reset");

endmodule
